// ===== sv/char_display_buffer_controller_assert.svh =====
// Assertion macros shared by the checker of the display buffer controller.
// No dependencies.
`ifndef CHAR_DISPLAY_BUFFER_CONTROLLER_ASSERT_SVH
`define CHAR_DISPLAY_BUFFER_CONTROLLER_ASSERT_SVH
`define CDB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define CDB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

// ===== sv/cdb_pkg.sv =====
// Package of the display buffer controller: opcodes, constants, the queue entry type and the state type.
// No dependencies.
package cdb_pkg;
    localparam int COLUMNS = 80;
    localparam int ROWS = 12;
    localparam int GLYPH_SLICES = 5;
    localparam int GLYPH_COUNT = 128;
    typedef enum logic [3:0] {
        OP_WRITE = 4'd0, OP_SETX = 4'd1, OP_SETY = 4'd2, OP_INCX = 4'd3,
        OP_ERASELINE = 4'd4, OP_ERASEFRAME = 4'd5, OP_SCROLLUP = 4'd6,
        OP_SCROLLDOWN = 4'd7, OP_CURSORON = 4'd8, OP_GLYPHSEL = 4'd9,
        OP_GLYPHLOAD = 4'd10, OP_READ = 4'd11, OP_CLRDIRTY = 4'd12
    } t_op;
    localparam logic [7:0] BLANK = 8'h20;
    localparam logic [6:0] SLICE_MASK = 7'h7F;
    typedef struct packed {
        logic [3:0] opcode;
        logic [7:0] value;
        logic [6:0] read_col;
        logic [3:0] read_row;
        logic [2:0] read_slice;
    } t_cmd;
    typedef enum logic [2:0] {
        S_IDLE, S_CLEAR, S_DISPATCH, S_SWEEP_RD, S_SWEEP_WR, S_READ_CELL,
        S_READ_GLYPH, S_DONE
    } t_state;
endpackage

// ===== sv/cdb_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module cdb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== sv/cdb_front.sv =====
// Front end: accepts requests into a two-entry queue.
// Depends on cdb_pkg.
module cdb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  cdb_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_pop,
    output cdb_pkg::t_cmd o_cmd
);
    import cdb_pkg::*;
    t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push;
    assign o_stall = (r_cnt == 2'd2);
    assign push = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rp];
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end
endmodule

// ===== sv/cdb_back.sv =====
// Back end: executes commands against the cell and glyph memories.
// Depends on cdb_pkg and cdb_ram.
module cdb_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_pop,
    input  cdb_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [7:0]    o_cell_char,
    output logic [6:0]    o_glyph_bits,
    output logic [6:0]    o_cur_x,
    output logic [3:0]    o_cur_y,
    output logic          o_cursor_shown,
    output logic          o_screen_changed,
    output logic          o_rejected
);
    import cdb_pkg::*;
    localparam int CELLS = COLUMNS * ROWS;
    localparam int CAW = $clog2(CELLS);
    localparam int GENTRIES = GLYPH_COUNT * GLYPH_SLICES;
    localparam int GAW = $clog2(GENTRIES);
    localparam int GW = $clog2(GLYPH_COUNT);
    localparam int SW = $clog2(GLYPH_SLICES);

    t_state r_state, n_state;
    t_cmd r_cmd, n_cmd;
    logic [6:0] r_x, n_x;
    logic [3:0] r_y, n_y;
    logic r_en, n_en, r_dirty, n_dirty, r_rej, n_rej;
    logic [GW-1:0] r_lg, n_lg;
    logic [SW-1:0] r_ls, n_ls;
    logic [CAW-1:0] r_ptr, n_ptr, r_end, n_end;
    logic r_blank, n_blank;
    logic [7:0] r_cc, n_cc;
    logic [6:0] r_gb, n_gb;
    logic r_ov, n_ov;

    logic c_we, g_we;
    logic [CAW-1:0] c_addr;
    logic [7:0] c_wdata, c_rdata;
    logic [GAW-1:0] g_addr;
    logic [6:0] g_rdata;
    logic [CAW-1:0] cursor_addr, read_addr;

    cdb_ram #(.WIDTH(8), .DEPTH(CELLS)) u_cells (
        .i_clk(i_clk), .i_we(c_we), .i_addr(c_addr), .i_wdata(c_wdata),
        .o_rdata(c_rdata));
    cdb_ram #(.WIDTH(7), .DEPTH(GENTRIES)) u_glyphs (
        .i_clk(i_clk), .i_we(g_we), .i_addr(g_addr), .i_wdata(r_cmd.value[6:0]),
        .o_rdata(g_rdata));

    assign cursor_addr = CAW'(32'(r_y) * COLUMNS + 32'(r_x));
    assign read_addr = CAW'(32'(r_cmd.read_row) * COLUMNS + 32'(r_cmd.read_col));
    assign o_valid = r_ov;
    assign o_cell_char = r_cc;
    assign o_glyph_bits = r_gb;
    assign o_cur_x = r_x;
    assign o_cur_y = r_y;
    assign o_cursor_shown = r_en;
    assign o_screen_changed = r_dirty;
    assign o_rejected = r_rej;

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_end <= n_end;
        r_blank <= n_blank;
        r_cc <= n_cc;
        r_gb <= n_gb;
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ptr <= '0;
            r_x <= '0;
            r_y <= '0;
            r_en <= 1'b0;
            r_dirty <= 1'b0;
            r_rej <= 1'b0;
            r_lg <= '0;
            r_ls <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr <= n_ptr;
            r_x <= n_x;
            r_y <= n_y;
            r_en <= n_en;
            r_dirty <= n_dirty;
            r_rej <= n_rej;
            r_lg <= n_lg;
            r_ls <= n_ls;
            r_ov <= n_ov;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cmd = r_cmd;
        n_x = r_x;
        n_y = r_y;
        n_en = r_en;
        n_dirty = r_dirty;
        n_rej = r_rej;
        n_lg = r_lg;
        n_ls = r_ls;
        n_ptr = r_ptr;
        n_end = r_end;
        n_blank = r_blank;
        n_cc = r_cc;
        n_gb = r_gb;
        n_ov = r_ov;
        o_pop = 1'b0;
        c_we = 1'b0;
        c_addr = r_ptr;
        c_wdata = BLANK;
        g_we = 1'b0;
        g_addr = GAW'(32'(r_lg) * GLYPH_SLICES + 32'(r_ls));
        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            S_CLEAR: begin
                c_we = 1'b1;
                n_ptr = r_ptr + 1'b1;
                if (r_ptr == CAW'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid && (!r_ov || !i_stall)) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_rej = 1'b0;
                n_cc = '0;
                n_gb = '0;
                n_state = S_DONE;
                case (r_cmd.opcode)
                    OP_WRITE: begin
                        c_we = 1'b1;
                        c_addr = cursor_addr;
                        c_wdata = r_cmd.value;
                        n_dirty = 1'b1;
                    end
                    OP_SETX: begin
                        if (32'(r_cmd.value) >= COLUMNS) begin
                            n_rej = 1'b1;
                        end else begin
                            n_x = r_cmd.value[6:0];
                            n_dirty = 1'b1;
                        end
                    end
                    OP_SETY: begin
                        if (32'(r_cmd.value) >= ROWS) begin
                            n_rej = 1'b1;
                        end else begin
                            n_y = r_cmd.value[3:0];
                            n_dirty = 1'b1;
                        end
                    end
                    OP_INCX: begin
                        if (32'(r_x) < COLUMNS - 1) begin
                            n_x = r_x + 7'd1;
                        end
                    end
                    OP_ERASELINE, OP_ERASEFRAME: begin
                        n_dirty = 1'b1;
                        n_ptr = cursor_addr;
                        n_blank = 1'b1;
                        if (r_cmd.opcode == OP_ERASELINE) begin
                            n_end = CAW'(32'(r_y) * COLUMNS + COLUMNS - 1);
                        end else begin
                            n_end = CAW'(CELLS - 1);
                        end
                        n_state = S_SWEEP_WR;
                    end
                    OP_SCROLLUP: begin
                        n_dirty = 1'b1;
                        n_ptr = '0;
                        n_blank = 1'b0;
                        n_state = S_SWEEP_RD;
                    end
                    OP_SCROLLDOWN: begin
                        n_dirty = 1'b1;
                        n_ptr = CAW'(CELLS - 1);
                        n_blank = 1'b0;
                        n_state = S_SWEEP_RD;
                    end
                    OP_CURSORON: n_en = r_cmd.value[0];
                    OP_GLYPHSEL: begin
                        n_lg = r_cmd.value[GW-1:0];
                        n_ls = '0;
                    end
                    OP_GLYPHLOAD: begin
                        g_we = 1'b1;
                        if (32'(r_ls) >= GLYPH_SLICES - 1) begin
                            n_ls = '0;
                            n_lg = r_lg + 1'b1;
                        end else begin
                            n_ls = r_ls + 1'b1;
                        end
                    end
                    OP_READ: begin
                        if (32'(r_cmd.read_col) < COLUMNS &&
                            32'(r_cmd.read_row) < ROWS) begin
                            c_addr = read_addr;
                            n_state = S_READ_CELL;
                        end
                    end
                    OP_CLRDIRTY: n_dirty = 1'b0;
                    default: ;
                endcase
            end
            S_SWEEP_RD: begin
                // Scroll: read the source cell, then write it at the destination.
                if (r_cmd.opcode == OP_SCROLLUP) begin
                    if (32'(r_ptr) >= CELLS - COLUMNS) begin
                        n_blank = 1'b1;
                    end else begin
                        c_addr = r_ptr + CAW'(COLUMNS);
                    end
                end else begin
                    if (32'(r_ptr) < COLUMNS) begin
                        n_blank = 1'b1;
                    end else begin
                        c_addr = r_ptr - CAW'(COLUMNS);
                    end
                end
                n_state = S_SWEEP_WR;
            end
            S_SWEEP_WR: begin
                c_we = 1'b1;
                c_wdata = r_blank ? BLANK : c_rdata;
                if (r_cmd.opcode == OP_SCROLLUP) begin
                    n_ptr = r_ptr + 1'b1;
                    n_state = (r_ptr == CAW'(CELLS - 1)) ? S_DONE : S_SWEEP_RD;
                end else if (r_cmd.opcode == OP_SCROLLDOWN) begin
                    n_ptr = r_ptr - 1'b1;
                    n_state = (r_ptr == '0) ? S_DONE : S_SWEEP_RD;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                    n_state = (r_ptr == r_end) ? S_DONE : S_SWEEP_WR;
                end
            end
            S_READ_CELL: begin
                n_cc = c_rdata;
                g_addr = GAW'(32'(c_rdata[GW-1:0]) * GLYPH_SLICES
                              + 32'(r_cmd.read_slice));
                n_state = S_READ_GLYPH;
            end
            S_READ_GLYPH: begin
                if (32'(r_cmd.read_slice) < GLYPH_SLICES) begin
                    n_gb = g_rdata & SLICE_MASK;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || !i_stall) begin
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== sv/char_display_buffer_controller.sv =====
// The back end executes one command at a time and takes no new command from the queue
// until it has produced the result of the last one.
// The front queue holds two further requests while the back end works.
// Reset is synchronous; afterwards every cell of the cell memory (ROWS*COLUMNS, 960 by default)
// is blanked, and no result is produced meanwhile.
// Depends on cdb_pkg, cdb_front, cdb_back.
module char_display_buffer_controller (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [3:0] i_opcode,
    input  logic [7:0] i_value,
    input  logic [6:0] i_read_col,
    input  logic [3:0] i_read_row,
    input  logic [2:0] i_read_slice,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_cell_char,
    output logic [6:0] o_glyph_bits,
    output logic [6:0] o_cur_x,
    output logic [3:0] o_cur_y,
    output logic       o_cursor_shown,
    output logic       o_screen_changed,
    output logic       o_rejected
);
    import cdb_pkg::*;
    t_cmd in_cmd, q_cmd;
    logic q_valid, q_pop;
    assign in_cmd = '{opcode: i_opcode, value: i_value, read_col: i_read_col,
                      read_row: i_read_row, read_slice: i_read_slice};
    cdb_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_cmd(in_cmd), .o_valid(q_valid), .i_pop(q_pop), .o_cmd(q_cmd));
    cdb_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_pop(q_pop),
        .i_cmd(q_cmd), .o_valid(o_valid), .i_stall(i_stall),
        .o_cell_char(o_cell_char), .o_glyph_bits(o_glyph_bits), .o_cur_x(o_cur_x),
        .o_cur_y(o_cur_y), .o_cursor_shown(o_cursor_shown),
        .o_screen_changed(o_screen_changed), .o_rejected(o_rejected));
endmodule

// ===== sv/cdb_checker.sv =====
// Port-level checker for the display buffer controller, bound to the top level.
// Depends on char_display_buffer_controller_assert.svh.
`include "char_display_buffer_controller_assert.svh"
module cdb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_cell_char,
    input logic [6:0] o_cur_x,
    input logic [3:0] o_cur_y,
    input logic       o_rejected
);
    `CDB_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_cell_char))
    `CDB_ASSERT_IMPL(a_xrange, i_clk, i_rst_n, o_valid, o_cur_x < 7'd80)
    `CDB_ASSERT_IMPL(a_yrange, i_clk, i_rst_n, o_valid, o_cur_y < 4'd12)
    `CDB_ASSERT_IMPL(a_rejread, i_clk, i_rst_n, o_valid && o_rejected, o_cell_char == 8'd0)
endmodule

bind char_display_buffer_controller cdb_checker u_cdb_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_cell_char(o_cell_char), .o_cur_x(o_cur_x), .o_cur_y(o_cur_y),
    .o_rejected(o_rejected));
